[rtl/tea_pkg.sv]
package tea_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_WORD0 = 2'd0,
        REG_KEY_WORD1 = 2'd1,
        REG_KEY_WORD2 = 2'd2,
        REG_KEY_WORD3 = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              cmd;
        logic [WORD_W-1:0] in_left;
        logic [WORD_W-1:0] in_right;
    } t_in;

    typedef struct packed {
        logic [WORD_W-1:0] out_left;
        logic [WORD_W-1:0] out_right;
    } t_out;

    typedef struct packed {
        logic [WORD_W-1:0] k0;
        logic [WORD_W-1:0] k1;
        logic [WORD_W-1:0] k2;
        logic [WORD_W-1:0] k3;
    } t_key;

    // round sum after n delta steps, wraps mod 2^32
    function automatic logic [WORD_W-1:0] tea_sum(input int unsigned n);
        logic [2*WORD_W-1:0] prod;
        prod = 64'(TEA_DELTA) * 64'(n);
        return prod[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] tea_mix(
        input logic [WORD_W-1:0] x,
        input logic [WORD_W-1:0] sum,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb
    );
        return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
    endfunction

endpackage

[rtl/tea_block_cipher.sv]
// TEA block cipher, fully unrolled: each 64-bit block (two 32-bit halves plus
// an encrypt/decrypt command) passes through 2*ROUNDS half-round register
// stages, one Feistel half-round per stage, then an output register with a
// one-entry skid buffer. A new block is taken every cycle while o_stall is
// low. Encryption runs the sum up from zero by delta 0x9e3779b9; decryption
// runs the inverse half-rounds starting at delta*ROUNDS (0xC6EF3720 for 32
// rounds), all mod 2^32. The 128-bit key sits in four 32-bit registers
// written through the config port (index 0..3 = key_word0..3, reset to
// zero); keys are read live by every stage, so write them only while no
// block is in flight. o_stall rises when the output is held and the skid
// entry fills, freezing the whole pipeline until it drains.
module tea_block_cipher #(
    parameter int unsigned ROUNDS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  tea_pkg::t_in               i_in,
    output logic                       o_valid,
    input  logic                       i_stall,
    output tea_pkg::t_out              o_out,
    input  logic                       i_cfg_we,
    input  logic [tea_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tea_pkg::WORD_W-1:0] i_cfg_data
);
    import tea_pkg::*;

    localparam int unsigned STAGES = 2 * ROUNDS;

    // key registers
    t_key r_key;

    // pipeline wiring, index 0 is the input side
    logic w_valid [0:STAGES];
    t_in  w_data  [0:STAGES];
    logic w_en;
    logic w_full;
    t_out w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_KEY_WORD0: r_key.k0 <= i_cfg_data;
                REG_KEY_WORD1: r_key.k1 <= i_cfg_data;
                REG_KEY_WORD2: r_key.k2 <= i_cfg_data;
                REG_KEY_WORD3: r_key.k3 <= i_cfg_data;
            endcase
        end
    end

    // whole pipeline advances unless the skid entry holds a result
    assign w_en       = !w_full;
    assign o_stall    = w_full;
    assign w_valid[0] = i_valid;
    assign w_data[0]  = i_in;

    for (genvar h = 0; h < STAGES; h++) begin : g_stage
        // round h/2 uses sum delta*(h/2+1) on encrypt, delta*(ROUNDS-h/2) on decrypt
        tea_half_round #(
            .SUM_ENC     (tea_sum(h / 2 + 1)),
            .SUM_DEC     (tea_sum(ROUNDS - h / 2)),
            .SECOND_HALF (1'((h % 2)))
        ) u_half_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[h]),
            .i_data  (w_data[h]),
            .i_key   (r_key),
            .o_valid (w_valid[h+1]),
            .o_data  (w_data[h+1])
        );
    end

    assign w_last.out_left  = w_data[STAGES].in_left;
    assign w_last.out_right = w_data[STAGES].in_right;

    // output register plus skid entry
    tea_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[STAGES]),
        .i_data  (w_last),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (o_out),
        .o_full  (w_full)
    );

`ifndef SYNTHESIS
    // skid only fills behind a held result
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("skid filled without a held output");

    // no skid content without a presented result
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("skid holds data while output is empty");

    // pipeline frozen while stalled
    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(w_valid[STAGES]))
        else $error("last stage moved during stall");
`endif

endmodule

[rtl/tea_half_round.sv]
module tea_half_round #(
    parameter logic [31:0] SUM_ENC     = 32'h0000_0000,
    parameter logic [31:0] SUM_DEC     = 32'h0000_0000,
    parameter bit          SECOND_HALF = 1'b0
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  tea_pkg::t_in i_data,
    input  tea_pkg::t_key i_key,
    output logic         o_valid,
    output tea_pkg::t_in o_data
);
    import tea_pkg::*;

    logic              r_valid;
    t_in               r_data;
    t_in               n_data;
    logic              w_enc;
    logic              w_upd_left;
    logic [WORD_W-1:0] w_x;
    logic [WORD_W-1:0] w_sum;
    logic [WORD_W-1:0] w_ka;
    logic [WORD_W-1:0] w_kb;
    logic [WORD_W-1:0] w_target;
    logic [WORD_W-1:0] w_mix;
    logic [WORD_W-1:0] w_new;

    // encrypt: left then right; decrypt: right then left
    assign w_enc      = (i_data.cmd == CMD_ENCRYPT);
    assign w_upd_left = w_enc ^ SECOND_HALF;
    assign w_x        = w_upd_left ? i_data.in_right : i_data.in_left;
    assign w_ka       = w_upd_left ? i_key.k0 : i_key.k2;
    assign w_kb       = w_upd_left ? i_key.k1 : i_key.k3;
    assign w_sum      = w_enc ? SUM_ENC : SUM_DEC;
    assign w_target   = w_upd_left ? i_data.in_left : i_data.in_right;
    assign w_mix      = tea_mix(w_x, w_sum, w_ka, w_kb);
    assign w_new      = w_enc ? (w_target + w_mix) : (w_target - w_mix);

    always_comb begin
        n_data = i_data;
        if (w_upd_left) begin
            n_data.in_left = w_new;
        end else begin
            n_data.in_right = w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[rtl/tea_out_buf.sv]
module tea_out_buf (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  tea_pkg::t_out i_data,
    input  logic          i_stall,
    output logic          o_valid,
    output tea_pkg::t_out o_data,
    output logic          o_full
);
    import tea_pkg::*;

    logic r_out_valid;
    t_out r_out;
    logic r_skid_valid;
    t_out r_skid;
    logic w_out_free;

    assign w_out_free = !r_out_valid || !i_stall;

    // upstream only moves while the skid entry is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
            end
        end else if (!r_skid_valid && i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_valid) begin
                r_out <= i_data;
            end
        end else if (!r_skid_valid && i_valid) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign o_full  = r_skid_valid;

endmodule
